// ----- design/prdt_pkg.sv -----
// ----------------------------------------------------------------------------
// prdt_pkg: shared types and constants for the pointer router / damage tracker
// Opcodes, result kinds, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package prdt_pkg;

  localparam logic [15:0] LEFT_BUTTON = 16'h0110;
  localparam int          MAX_SCREEN  = 4096;
  // window slots; slot and focus port widths are sized for this count
  localparam int          SLOTS       = 8;

  typedef enum logic [3:0] {
    OP_MOVE_X   = 4'd0,
    OP_MOVE_Y   = 4'd1,
    OP_BUTTON   = 4'd2,
    OP_KEY      = 4'd3,
    OP_END      = 4'd4,
    OP_WRITE    = 4'd5,
    OP_REMOVE   = 4'd6,
    OP_CDAMAGE  = 4'd7,
    OP_TAKE     = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    KIND_MOTION = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_KEY    = 2'd2,
    KIND_DAMAGE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DMG_A,
    ST_UPDATE,
    ST_DMG_B,
    ST_DONE
  } state_e;

  // Source of the rectangle fed to the damage merge unit
  typedef enum logic [2:0] {
    DS_NONE,
    DS_FRAME_FOCUS,
    DS_FRAME_HIT,
    DS_FRAME_SLOT,
    DS_CURSOR_OLD,
    DS_CURSOR_NEW,
    DS_CLIENT
  } dsrc_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic  latch;     // capture the input word
    logic  exec;      // cursor move and clamp; hit test follows in DMG_A
    dsrc_e dmg;       // rectangle to merge this cycle
    logic  update;    // table / focus / batch update
    logic  emit;      // drive result strobe
  } ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    op_e  op;
    logic hit;
    logic focus_move;
    logic slot_used;
    logic cursor_moved;
    logic key_ok;
  } sts_t;

endpackage
`default_nettype wire

// ----- design/prdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// prdt_ctrl: command sequencer
// Steps one word through execute, up to two damage merges and the update.
// ----------------------------------------------------------------------------
`default_nettype none
module prdt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  prdt_pkg::sts_t     sts_i,
  output prdt_pkg::ctl_t     ctl_o
);
  import prdt_pkg::*;

  state_e state_q, state_d;
  logic   emit_d, emit_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    emit_d     = emit_q;
    ctl_o      = '0;
    ctl_o.dmg  = DS_NONE;
    busy       = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctl_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = ST_DMG_A;
      end
      ST_DMG_A: begin
        case (sts_i.op)
          OP_BUTTON: if (sts_i.focus_move) ctl_o.dmg = DS_FRAME_FOCUS;
          OP_END:    if (sts_i.cursor_moved) ctl_o.dmg = DS_CURSOR_OLD;
          OP_WRITE, OP_REMOVE: ctl_o.dmg = DS_FRAME_SLOT;
          OP_CDAMAGE: if (sts_i.slot_used) ctl_o.dmg = DS_CLIENT;
          default: ctl_o.dmg = DS_NONE;
        endcase
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl_o.update = 1'b1;
        state_d      = ST_DMG_B;
      end
      ST_DMG_B: begin
        case (sts_i.op)
          OP_BUTTON: if (sts_i.focus_move) ctl_o.dmg = DS_FRAME_HIT;
          OP_END:    if (sts_i.cursor_moved) ctl_o.dmg = DS_CURSOR_NEW;
          OP_WRITE:  ctl_o.dmg = DS_FRAME_SLOT;
          default:   ctl_o.dmg = DS_NONE;
        endcase
        case (sts_i.op)
          OP_BUTTON, OP_END: emit_d = sts_i.hit;
          OP_KEY:            emit_d = sts_i.key_ok;
          OP_TAKE:           emit_d = 1'b1;
          default:           emit_d = 1'b0;
        endcase
        state_d = ST_DONE;
      end
      ST_DONE: begin
        ctl_o.emit = emit_q;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/prdt_dpath.sv -----
// ----------------------------------------------------------------------------
// prdt_dpath: window table, cursor, focus and damage box
// Hit test over all slots in parallel; one damage rectangle merged per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module prdt_dpath #(
  parameter int CURSOR_WIDTH  = 10,
  parameter int CURSOR_HEIGHT = 14,
  parameter int TITLE_HEIGHT  = 18,
  parameter int FRAME_WIDTH   = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  prdt_pkg::ctl_t            ctl_i,
  output prdt_pkg::sts_t            sts_o,
  input  wire logic                 cfg_valid_i,
  input  wire logic [0:0]           cfg_index_i,
  input  wire logic [12:0]          cfg_data_i,
  input  wire logic                 cfg_other_i,
  input  wire logic [3:0]           opcode_i,
  input  wire logic signed [15:0]   delta_i,
  input  wire logic [15:0]          event_code_i,
  input  wire logic [15:0]          event_value_i,
  input  wire logic [2:0]           slot_i,
  input  wire logic signed [12:0]   pos_x_i,
  input  wire logic signed [12:0]   pos_y_i,
  input  wire logic [12:0]          size_w_i,
  input  wire logic [12:0]          size_h_i,
  input  wire logic                 shell_flag_i,
  output logic                      done_o,
  output logic [1:0]                kind_o,
  output logic [2:0]                target_slot_o,
  output logic signed [13:0]        local_x_o,
  output logic signed [13:0]        local_y_o,
  output logic [15:0]               out_code_o,
  output logic [15:0]               out_value_o,
  output logic [12:0]               box_left_o,
  output logic [12:0]               box_top_o,
  output logic [12:0]               box_right_o,
  output logic [12:0]               box_bottom_o,
  output logic                      box_valid_o,
  output logic [3:0]                focused_o
);
  import prdt_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW = $clog2(SLOTS + 1);
  localparam logic [FW-1:0] NO_FOCUS = FW'(SLOTS);

  // screen registers
  logic [12:0] scr_w_q, scr_h_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= 13'd1024;
      scr_h_q <= 13'd768;
    end else if (cfg_valid_i && !cfg_other_i) begin
      if (cfg_index_i == 1'b0) scr_w_q <= cfg_data_i;
      else                     scr_h_q <= cfg_data_i;
    end
  end
  logic [12:0] eff_w, eff_h;
  assign eff_w = (scr_w_q == 13'd0) ? 13'd1 : (scr_w_q > 13'(MAX_SCREEN)) ? 13'(MAX_SCREEN)
               : scr_w_q;
  assign eff_h = (scr_h_q == 13'd0) ? 13'd1 : (scr_h_q > 13'(MAX_SCREEN)) ? 13'(MAX_SCREEN)
               : scr_h_q;

  // latched input word
  op_e                op_q;
  logic signed [15:0] delta_q;
  logic [15:0]        code_q, val_q;
  logic [2:0]         slot_q;
  logic signed [12:0] px_q, py_q;
  logic [12:0]        sw_q, sh_q;
  logic               shell_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      op_q    <= op_e'(opcode_i);
      delta_q <= delta_i;
      code_q  <= event_code_i;
      val_q   <= event_value_i;
      slot_q  <= slot_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      sw_q    <= size_w_i;
      sh_q    <= size_h_i;
      shell_q <= shell_flag_i;
    end
  end

  // window table
  logic               used_q [SLOTS];
  logic               shl_q  [SLOTS];
  logic signed [12:0] wx_q   [SLOTS];
  logic signed [12:0] wy_q   [SLOTS];
  logic [12:0]        ww_q   [SLOTS];
  logic [12:0]        wh_q   [SLOTS];

  logic signed [15:0] cx_q, cy_q, bx_q, by_q;
  logic [FW-1:0]      focus_q;
  logic [12:0]        bl_q, bt_q, br_q, bb_q;
  logic               bv_q;

  logic               slot_ok;
  logic [SW-1:0]      sidx;
  assign slot_ok = ({1'b0, slot_q} < 4'(SLOTS));
  assign sidx    = SW'(slot_q);

  // cursor after move / clamp
  logic signed [16:0] cx_sum, cy_sum;
  logic signed [15:0] cx_n, cy_n;
  assign cx_sum = 17'(cx_q) + 17'(delta_q);
  assign cy_sum = 17'(cy_q) + 17'(delta_q);
  always_comb begin
    cx_n = cx_q;
    cy_n = cy_q;
    if (op_q == OP_MOVE_X)
      cx_n = (cx_sum > 17'sd32767) ? 16'sh7fff : (cx_sum < -17'sd32768) ? 16'sh8000
           : 16'(cx_sum);
    if (op_q == OP_MOVE_Y)
      cy_n = (cy_sum > 17'sd32767) ? 16'sh7fff : (cy_sum < -17'sd32768) ? 16'sh8000
           : 16'(cy_sum);
    if (op_q == OP_END) begin
      if (cx_n < 0) cx_n = '0;
      if (cy_n < 0) cy_n = '0;
      if (cx_n >= $signed({3'b0, eff_w})) cx_n = $signed({3'b0, eff_w}) - 16'sd1;
      if (cy_n >= $signed({3'b0, eff_h})) cy_n = $signed({3'b0, eff_h}) - 16'sd1;
    end
  end

  // hit test: cursor inside each occupied window
  logic [SLOTS-1:0] in_win;
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      in_win[i] = used_q[i]
        && 18'(cx_q) >= 18'(wx_q[i]) && 18'(cx_q) < 18'(wx_q[i]) + $signed({5'b0, ww_q[i]})
        && 18'(cy_q) >= 18'(wy_q[i]) && 18'(cy_q) < 18'(wy_q[i]) + $signed({5'b0, wh_q[i]});
    end
  end
  // highest matching slot of each kind; non-shell wins over shell
  logic          hs_c, hn_c;
  logic [SW-1:0] ihs_c, ihn_c;
  always_comb begin
    hs_c = 1'b0; hn_c = 1'b0; ihs_c = '0; ihn_c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (in_win[i] && shl_q[i])  begin hs_c = 1'b1; ihs_c = SW'(i); end
      if (in_win[i] && !shl_q[i]) begin hn_c = 1'b1; ihn_c = SW'(i); end
    end
  end

  logic          hit_q_r;
  logic [SW-1:0] hit_idx_q;
  logic signed [13:0] lx_q, ly_q;
  logic          focus_move_q;
  logic          moved_q;

  // execute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= 16'sd512;
      cy_q <= 16'sd384;
    end else if (ctl_i.exec) begin
      cx_q <= cx_n;
      cy_q <= cy_n;
    end
  end

  // hit test runs in the cycle after exec on the clamped cursor (DMG_A)
  logic               hit_v;
  logic [SW-1:0]      hit_i;
  assign hit_v = hn_c | hs_c;
  assign hit_i = hn_c ? ihn_c : ihs_c;

  // hit result captured at damage phase A
  logic phase_a_q, phase_b_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_a_q <= 1'b0;
      phase_b_q <= 1'b0;
    end else begin
      phase_a_q <= ctl_i.exec;
      phase_b_q <= ctl_i.update;
    end
  end
  logic phase_a;
  assign phase_a = !ctl_i.exec && !ctl_i.update && !ctl_i.latch && !ctl_i.emit
                   && !phase_b_q && phase_a_q;

  logic [SW-1:0] hidx;
  logic          hvalid;
  assign hidx   = phase_a ? hit_i : hit_idx_q;
  assign hvalid = phase_a ? hit_v : hit_q_r;

  // cursor moved since batch start, held past the batch update
  logic moved_c;
  assign moved_c = (cx_q != bx_q) || (cy_q != by_q);

  always_ff @(posedge clk_i) begin
    if (phase_a) begin
      hit_q_r   <= hit_v;
      hit_idx_q <= hit_i;
      lx_q      <= 14'(cx_q) - 14'(wx_q[hit_i]);
      ly_q      <= 14'(cy_q) - 14'(wy_q[hit_i]);
      focus_move_q <= hit_v && (val_q == 16'd1) && (FW'(hit_i) != focus_q);
      moved_q   <= moved_c;
    end
  end
  logic fm;
  assign fm = phase_a ? (hit_v && (val_q == 16'd1) && (FW'(hidx) != focus_q))
                      : focus_move_q;

  // status
  logic focus_in;
  assign focus_in = (focus_q < NO_FOCUS);
  assign sts_o.op           = op_q;
  assign sts_o.hit          = hvalid && (op_q == OP_END || code_q == LEFT_BUTTON);
  assign sts_o.focus_move   = fm && (code_q == LEFT_BUTTON);
  assign sts_o.slot_used    = slot_ok && used_q[sidx];
  assign sts_o.cursor_moved = phase_a ? moved_c : moved_q;
  assign sts_o.key_ok       = focus_in && used_q[SW'(focus_q)];

  // damage rectangle select
  logic [SW-1:0]      fs;
  logic               fs_ok;
  logic signed [15:0] rx, ry;
  logic signed [15:0] rw, rh;
  always_comb begin
    fs    = sidx;
    fs_ok = 1'b0;
    rx = '0; ry = '0; rw = '0; rh = '0;
    case (ctl_i.dmg)
      DS_FRAME_FOCUS: begin fs = SW'(focus_q); fs_ok = focus_in; end
      DS_FRAME_HIT:   begin fs = hit_idx_q;    fs_ok = 1'b1;     end
      DS_FRAME_SLOT:  begin fs = sidx;         fs_ok = slot_ok;  end
      default: ;
    endcase
    case (ctl_i.dmg)
      DS_FRAME_FOCUS, DS_FRAME_HIT, DS_FRAME_SLOT: begin
        if (fs_ok && used_q[fs]) begin
          if (shl_q[fs]) begin
            rx = 16'(wx_q[fs]); ry = 16'(wy_q[fs]);
            rw = $signed({3'b0, ww_q[fs]}); rh = $signed({3'b0, wh_q[fs]});
          end else begin
            rx = 16'(wx_q[fs]) - 16'(FRAME_WIDTH);
            ry = 16'(wy_q[fs]) - 16'(TITLE_HEIGHT + FRAME_WIDTH);
            rw = $signed({3'b0, ww_q[fs]}) + 16'(2 * FRAME_WIDTH);
            rh = $signed({3'b0, wh_q[fs]}) + 16'(TITLE_HEIGHT + 2 * FRAME_WIDTH);
          end
        end
      end
      DS_CURSOR_OLD: begin
        rx = bx_q; ry = by_q; rw = 16'(CURSOR_WIDTH); rh = 16'(CURSOR_HEIGHT);
      end
      DS_CURSOR_NEW: begin
        rx = cx_q; ry = cy_q; rw = 16'(CURSOR_WIDTH); rh = 16'(CURSOR_HEIGHT);
      end
      DS_CLIENT: begin
        rx = 16'(wx_q[sidx]) + 16'(px_q); ry = 16'(wy_q[sidx]) + 16'(py_q);
        rw = $signed({3'b0, sw_q}); rh = $signed({3'b0, sh_q});
      end
      default: ;
    endcase
  end

  // clip and union
  logic signed [17:0] x0, y0, x1, y1;
  logic               rect_ok;
  always_comb begin
    x0 = 18'(rx); y0 = 18'(ry);
    x1 = 18'(rx) + 18'(rw); y1 = 18'(ry) + 18'(rh);
    rect_ok = (rw > 0) && (rh > 0);
    if (x0 < 0) x0 = '0;
    if (y0 < 0) y0 = '0;
    if (x1 > $signed({5'b0, eff_w})) x1 = $signed({5'b0, eff_w});
    if (y1 > $signed({5'b0, eff_h})) y1 = $signed({5'b0, eff_h});
    rect_ok = rect_ok && (x1 > x0) && (y1 > y0);
  end

  // box, focus, batch start and table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q <= '0; bt_q <= '0; br_q <= 13'd1024; bb_q <= 13'd768; bv_q <= 1'b1;
      focus_q <= NO_FOCUS;
      bx_q <= 16'sd512; by_q <= 16'sd384;
      for (int i = 0; i < SLOTS; i++) used_q[i] <= 1'b0;
    end else begin
      if (rect_ok) begin
        if (!bv_q) begin
          bl_q <= 13'(x0); bt_q <= 13'(y0); br_q <= 13'(x1); bb_q <= 13'(y1);
          bv_q <= 1'b1;
        end else begin
          if (13'(x0) < bl_q) bl_q <= 13'(x0);
          if (13'(y0) < bt_q) bt_q <= 13'(y0);
          if (13'(x1) > br_q) br_q <= 13'(x1);
          if (13'(y1) > bb_q) bb_q <= 13'(y1);
        end
      end
      if (ctl_i.emit && op_q == OP_TAKE) bv_q <= 1'b0;
      if (ctl_i.update) begin
        case (op_q)
          OP_BUTTON: if (sts_o.focus_move) focus_q <= FW'(hit_idx_q);
          OP_END: begin bx_q <= cx_q; by_q <= cy_q; end
          OP_WRITE: if (slot_ok) begin
            used_q[sidx] <= 1'b1;
            if (!focus_in) focus_q <= FW'(sidx);
          end
          OP_REMOVE: if (slot_ok) used_q[sidx] <= 1'b0;
          default: ;
        endcase
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.update && op_q == OP_WRITE && slot_ok) begin
      shl_q[sidx] <= shell_q;
      wx_q[sidx]  <= px_q;
      wy_q[sidx]  <= py_q;
      ww_q[sidx]  <= sw_q;
      wh_q[sidx]  <= sh_q;
    end
  end

  // result drive
  always_comb begin
    done_o        = ctl_i.emit;
    kind_o        = KIND_DAMAGE;
    target_slot_o = '0;
    local_x_o     = '0;
    local_y_o     = '0;
    out_code_o    = '0;
    out_value_o   = '0;
    case (op_q)
      OP_BUTTON: begin
        kind_o = KIND_BUTTON; target_slot_o = 3'(hit_idx_q);
        local_x_o = lx_q; local_y_o = ly_q; out_code_o = code_q; out_value_o = val_q;
      end
      OP_END: begin
        kind_o = KIND_MOTION; target_slot_o = 3'(hit_idx_q);
        local_x_o = lx_q; local_y_o = ly_q;
      end
      OP_KEY: begin
        kind_o = KIND_KEY; target_slot_o = 3'(focus_q);
        out_code_o = code_q; out_value_o = val_q;
      end
      default: ;
    endcase
    box_left_o   = bv_q ? bl_q : '0;
    box_top_o    = bv_q ? bt_q : '0;
    box_right_o  = bv_q ? br_q : '0;
    box_bottom_o = bv_q ? bb_q : '0;
    box_valid_o  = bv_q;
    focused_o    = 4'(focus_q);
  end

endmodule
`default_nettype wire

// ----- design/pointer_router_damage_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// pointer_router_damage_tracker_unit: pointer routing and damage tracking
// Window table, cursor, focus and damage bounding box for a compositor.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an input word while busy is low; the word is taken at
//   that edge and busy stays high until the word is finished.
//   After acceptance each word steps through execute, first damage merge,
//   table update, second damage merge and result, then busy drops. The two
//   merges go through one shared clip-and-union unit, which sets the length of the sequence.
//   A new word is taken only once busy has dropped, in an idle cycle.
//   A result, if any, shows on the result ports for one cycle with
//   result_valid_o high, in the last cycle of the word. The receiver cannot
//   stall it.
//   Screen size registers are written on cfg_valid_i/cfg_ready_o, index 0
//   width and 1 height; cfg_ready_o is always high.
//   Reset: cursor mid screen, no focus, all slots free, full-screen damage.
// ----------------------------------------------------------------------------
`default_nettype none
module pointer_router_damage_tracker_unit #(
  parameter int CURSOR_WIDTH  = 10,
  parameter int CURSOR_HEIGHT = 14,
  parameter int TITLE_HEIGHT  = 18,
  parameter int FRAME_WIDTH   = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [7:0]          cfg_index_i,
  input  wire logic [12:0]         cfg_data_i,
  input  wire logic [3:0]          opcode_i,
  input  wire logic signed [15:0]  delta_i,
  input  wire logic [15:0]         event_code_i,
  input  wire logic [15:0]         event_value_i,
  input  wire logic [2:0]          slot_i,
  input  wire logic signed [12:0]  pos_x_i,
  input  wire logic signed [12:0]  pos_y_i,
  input  wire logic [12:0]         size_w_i,
  input  wire logic [12:0]         size_h_i,
  input  wire logic                shell_flag_i,
  output logic                     result_valid_o,
  output logic [1:0]               kind_o,
  output logic [2:0]               target_slot_o,
  output logic signed [13:0]       local_x_o,
  output logic signed [13:0]       local_y_o,
  output logic [15:0]              out_code_o,
  output logic [15:0]              out_value_o,
  output logic [12:0]              box_left_o,
  output logic [12:0]              box_top_o,
  output logic [12:0]              box_right_o,
  output logic [12:0]              box_bottom_o,
  output logic                     box_valid_o,
  output logic [3:0]               focused_o
);
  import prdt_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  prdt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .sts_i(sts), .ctl_o(ctl)
  );

  prdt_dpath #(
    .CURSOR_WIDTH(CURSOR_WIDTH), .CURSOR_HEIGHT(CURSOR_HEIGHT),
    .TITLE_HEIGHT(TITLE_HEIGHT), .FRAME_WIDTH(FRAME_WIDTH)
  ) u_dpath (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .cfg_valid_i, .cfg_index_i(cfg_index_i[0]), .cfg_data_i,
    .cfg_other_i(|cfg_index_i[7:1]),
    .opcode_i, .delta_i, .event_code_i, .event_value_i, .slot_i, .pos_x_i, .pos_y_i,
    .size_w_i, .size_h_i, .shell_flag_i,
    .done_o(result_valid_o), .kind_o, .target_slot_o, .local_x_o, .local_y_o,
    .out_code_o, .out_value_o, .box_left_o, .box_top_o, .box_right_o, .box_bottom_o,
    .box_valid_o, .focused_o
  );

endmodule
`default_nettype wire

// ----- design/prdt_checker.sv -----
// ----------------------------------------------------------------------------
// prdt_checker: port-level checks for the pointer router
// Result timing against busy, and box/focus consistency.
// ----------------------------------------------------------------------------
`default_nettype none
module prdt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid_o,
  input wire logic [1:0]  kind_o,
  input wire logic        box_valid_o,
  input wire logic [12:0] box_left_o,
  input wire logic [12:0] box_right_o,
  input wire logic [3:0]  focused_o
);
  // a result only in the last busy cycle
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside busy");
  a_res_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy) else $error("result not at end");
  // accepted word is finished, with busy low again, at the end of its sequence
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 !busy) else $error("word length");
  // valid box is ordered
  a_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && box_valid_o) |-> (box_left_o < box_right_o))
    else $error("box order");
  a_foc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == 2'd2) |-> (focused_o < 4'd8)) else $error("key focus");
endmodule

bind pointer_router_damage_tracker_unit prdt_checker u_chk (.*);
`default_nettype wire
